### design/dcdec_pkg.sv
package dcdec_pkg;

	// filter state slots, one per channel (1 or 2)
	localparam int MAX_CHANNELS = 2;
	localparam int SLOT_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int IN_W         = 32;
	localparam int OUT_W        = 16;
	localparam int DC_SHIFT     = 10;
	localparam int CFG_IDX_W    = 8;

	// frame group of three: phase 0 is kept
	localparam logic [1:0] PHASE_KEEP = 2'd0;
	localparam logic [1:0] PHASE_LAST = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEREO_MODE = 8'd0,
		REG_DC_ENABLE   = 8'd1
	} cfg_reg_t;

	// kept sample waiting in the input register
	typedef struct packed {
		logic             valid;
		logic [OUT_W-1:0] sample;
		logic             ch;
	} s1_t;

endpackage

### design/dcdec_framer.sv
module dcdec_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [dcdec_pkg::IN_W-1:0] sample_in,
	input  logic                        stereo_mode,
	input  logic                        s1_take,
	output dcdec_pkg::s1_t              s1
);
	import dcdec_pkg::*;

	logic [1:0]       phase_q;
	logic             chan_idx_q;
	logic             s1_valid_q;
	logic [OUT_W-1:0] s1_sample_q;
	logic             s1_ch_q;
	logic             in_accept;
	logic             ch;
	logic             last;
	logic             keep;

	assign in_ready  = !s1_valid_q || s1_take;
	assign in_accept = in_valid && in_ready;
	assign ch        = stereo_mode ? chan_idx_q : 1'b0;
	assign last      = !stereo_mode || ch;
	assign keep      = (phase_q == PHASE_KEEP);
	assign s1        = '{valid: s1_valid_q, sample: s1_sample_q, ch: s1_ch_q};

	// frame position and channel tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			chan_idx_q <= 1'b0;
		end else if (in_accept) begin
			if (last) begin
				chan_idx_q <= 1'b0;
				phase_q    <= (phase_q >= PHASE_LAST) ? PHASE_KEEP : phase_q + 2'd1;
			end else begin
				chan_idx_q <= 1'b1;
			end
		end
	end

	// input register holds kept samples only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept && keep) begin
			s1_valid_q <= 1'b1;
		end else if (s1_take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && keep) begin
			s1_sample_q <= sample_in[IN_W-1 -: OUT_W];
			s1_ch_q     <= ch;
		end
	end

endmodule

### design/dcdec_filter.sv
module dcdec_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dcdec_pkg::s1_t                     s1,
	output logic                               s1_take,
	input  logic                               dc_enable,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [dcdec_pkg::OUT_W-1:0] sample_out,
	output logic                               channel_out
);
	import dcdec_pkg::*;

	logic [OUT_W-1:0]        prev_in_q  [MAX_CHANNELS];
	logic signed [IN_W-1:0]  prev_out_q [MAX_CHANNELS];
	logic                    out_valid_q;
	logic [OUT_W-1:0]        sample_q;
	logic                    chan_q;
	logic [SLOT_W-1:0]       slot;
	logic signed [IN_W-1:0]  x;
	logic signed [IN_W-1:0]  xp;
	logic signed [IN_W-1:0]  yp;
	logic signed [IN_W-1:0]  y;
	logic [OUT_W-1:0]        result;

	assign s1_take = s1.valid && (!out_valid_q || out_ready);

	// single-channel build folds the right channel onto slot 0
	assign slot = (s1.ch && (MAX_CHANNELS > 1)) ? SLOT_W'(1) : '0;

	// y = x - x_prev + y_prev - (y_prev >>> 10), wrapping at 32 bits
	assign x  = {s1.sample, {(IN_W-OUT_W){1'b0}}};
	assign xp = {prev_in_q[slot], {(IN_W-OUT_W){1'b0}}};
	assign yp = prev_out_q[slot];
	assign y  = x - xp + (yp - (yp >>> DC_SHIFT));

	assign result = dc_enable ? y[IN_W-1 -: OUT_W] : s1.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				prev_in_q[i]  <= '0;
				prev_out_q[i] <= '0;
			end
		end else if (s1_take && dc_enable) begin
			prev_in_q[slot]  <= s1.sample;
			prev_out_q[slot] <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			sample_q <= result;
			chan_q   <= s1.ch;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_q;
	assign channel_out = chan_q;

endmodule

### design/decimate_and_dc_block_top.sv
// decimate-by-three capture path with optional per-channel dc blocking. takes signed 32-bit
// samples, mono or stereo interleaved left first, keeps the first frame of every three and
// drops the rest; a kept sample is cut to its top 16 bits and, with dc_enable set, run through
// y = x - x_prev + y_prev - (y_prev >>> 10) in q31 with a separate state per channel, the top
// 16 bits of y being the result. one sample is accepted every cycle while the output is not stalled;
// a kept sample goes through the input register, then the result register, to the output, and the
// filter add path between those two registers sets the cycle. when the output stalls, the
// input register fills and in_ready drops until the result is taken. configuration writes
// are always accepted and should only be issued while the block is idle.
module decimate_and_dc_block_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample input
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [dcdec_pkg::IN_W-1:0]      sample_in,
	// decimated output
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [dcdec_pkg::OUT_W-1:0]     sample_out,
	output logic                                   channel_out,
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [dcdec_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic                                   cfg_data
);
	import dcdec_pkg::*;

	logic stereo_mode_q;
	logic dc_enable_q;
	logic s1_take;
	s1_t  s1;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b0;
			dc_enable_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEREO_MODE: stereo_mode_q <= cfg_data;
				REG_DC_ENABLE:   dc_enable_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame counting, channel tracking and input register
	dcdec_framer u_framer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.stereo_mode (stereo_mode_q),
		.s1_take     (s1_take),
		.s1          (s1)
	);

	// high-pass filter state and result register
	dcdec_filter u_filter (
		.clk         (clk),
		.arst_n      (arst_n),
		.s1          (s1),
		.s1_take     (s1_take),
		.dc_enable   (dc_enable_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.channel_out (channel_out)
	);

endmodule

### design/dcdec_checker.sv
module dcdec_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [dcdec_pkg::OUT_W-1:0]  sample_out,
	input logic                                channel_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(channel_out))
		else $error("result changed while stalled");

	// input back-pressure only comes from a stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// a free output keeps the input open
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output ready");

	// nothing comes out right after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind decimate_and_dc_block_top dcdec_checker u_dcdec_checker (.*);

### sim/dcdec_check.sv
`timescale 1ns / 1ps

module dcdec_check
	import dcdec_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [IN_W-1:0]  sample_in,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [OUT_W-1:0] sample_out,
	input  logic                    channel_out,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic                    cfg_data,
	output int                      fail_count,
	output int                      pending,
	output int                      requests_taken,
	output int                      results_checked
);

	typedef struct packed {
		logic [OUT_W-1:0] sample;
		logic             ch;
	} dec_sample_t;

	dec_sample_t      expected_samples [$];

	// shadow of the block's settings and filter state
	logic             stereo_on;
	logic             dc_on;
	logic [1:0]       frame_phase;
	logic             chan_idx;
	logic [OUT_W-1:0] x_hist [MAX_CHANNELS];
	logic [31:0]      y_hist [MAX_CHANNELS];

	int               mismatches;
	int               n_requests;
	int               n_results;

	task automatic note_failure(input string what, input dec_sample_t want);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected %0d ch %0d, got %0d ch %0d", $realtime, what,
				$signed(want.sample), want.ch, sample_out, channel_out);
		end
	endtask

	// decimate by three, cut to 16 bits, optional dc blocking per channel
	task automatic decimate_and_filter(input logic [IN_W-1:0] raw);
		logic              ch;
		logic              last;
		int                slot;
		logic [OUT_W-1:0]  v;
		logic [31:0]       x;
		logic [31:0]       xp;
		logic [31:0]       y;
		logic signed [31:0] yp;
		logic signed [31:0] leak;
		dec_sample_t       e;
		ch   = stereo_on ? chan_idx : 1'b0;
		last = !stereo_on || ch;
		if (frame_phase == PHASE_KEEP) begin
			v = raw[IN_W-1 -: OUT_W];
			if (dc_on) begin
				slot = (int'(ch) < MAX_CHANNELS) ? int'(ch) : 0;
				x    = {v, 16'h0000};
				xp   = {x_hist[slot], 16'h0000};
				yp   = y_hist[slot];
				leak = yp >>> DC_SHIFT;
				y    = x - xp + (yp - leak);
				x_hist[slot] = v;
				y_hist[slot] = y;
				v = y[31:16];
			end
			e.sample = v;
			e.ch     = ch;
			expected_samples.push_back(e);
		end
		if (last) begin
			chan_idx    = 1'b0;
			frame_phase = (frame_phase >= PHASE_LAST) ? PHASE_KEEP : frame_phase + 2'd1;
		end else begin
			chan_idx = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dec_sample_t want;
		if (!arst_n) begin
			stereo_on   = 1'b0;
			dc_on       = 1'b0;
			frame_phase = PHASE_KEEP;
			chan_idx    = 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			expected_samples.delete();
			mismatches      = 0;
			n_requests      = 0;
			n_results       = 0;
			fail_count      <= 0;
			pending         <= 0;
			requests_taken  <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEREO_MODE: stereo_on = cfg_data;
					REG_DC_ENABLE:   dc_on = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_samples.size() == 0) begin
					want = '0;
					note_failure("result with nothing outstanding", want);
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want.sample || channel_out !== want.ch)
						note_failure("sample mismatch", want);
				end
			end
			if (in_valid && in_ready) begin
				n_requests++;
				decimate_and_filter(sample_in);
			end
			fail_count      <= mismatches;
			pending         <= expected_samples.size();
			requests_taken  <= n_requests;
			results_checked <= n_results;
		end
	end

endmodule

### sim/tb_decimate_and_dc_block_top.sv
`timescale 1ns / 1ps

module tb_decimate_and_dc_block_top;
	import dcdec_pkg::*;

	// run limit in cycles, far above the slowest legal run
	localparam int CYCLE_LIMIT = 300000;
	// long output hold used to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	// two-stage pipe plus margin for a dropped sample still in flight
	localparam int SETTLE_CYCLES = 6;
	localparam int N_PHASES = 8;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [IN_W-1:0]  sample_in;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [OUT_W-1:0] sample_out;
	logic                    channel_out;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic                    cfg_data;

	int fail_count;
	int pending;
	int requests_taken;
	int results_checked;

	// receiver controls, set from the stimulus side
	int   stall_pct;
	logic pressure_on;
	logic hold_done;

	// sender burst state
	int   burst_left;
	logic steady_sender;
	int   cycle_count;
	int   settings_used;

	decimate_and_dc_block_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.channel_out (channel_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	dcdec_check checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_in       (sample_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_out      (sample_out),
		.channel_out     (channel_out),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.requests_taken  (requests_taken),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stalls at the current rate, and one long hold each time
	// pressure is switched on, so the input side has to back up
	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_on && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (!pressure_on)
					hold_done = 1'b0;
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// one sample request; gaps only fall between bursts, and valid is only
	// dropped when a real gap follows, so it never toggles within one step
	task automatic send_sample(input logic [IN_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	// wait until every kept sample has come out, then let dropped ones clear
	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mix of full-scale, near-zero, offset-plus-noise and raw random samples;
	// the offset case gives the dc blocker something real to remove
	function automatic logic [IN_W-1:0] pick_sample(input logic [IN_W-1:0] dc_level);
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return {{15{r[31]}}, r[16:0]};
			3, 4, 5: return dc_level + (r & 32'h03FF_FFFF) - 32'h0200_0000;
			default: return r;
		endcase
	endfunction

	initial begin
		logic        st;
		logic        dc;
		int          n;
		logic [31:0] dc_level;

		// every input known from time zero
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		sample_in     = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_STEREO_MODE;
		cfg_data      = 1'b0;
		stall_pct     = 0;
		pressure_on   = 1'b0;
		burst_left    = 0;
		steady_sender = 1'b0;
		settings_used = 1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// mono, no filter (reset settings): full-scale extremes on kept frames
		send_sample(32'h7FFF_FFFF);
		send_sample($urandom);
		send_sample($urandom);
		send_sample(32'h8000_0000);
		send_sample($urandom);
		send_sample($urandom);
		send_sample(32'h0000_FFFF);
		stop_sending();
		settle();

		// mono with dc blocking; phase is now 1, so two drops come first.
		// a full-scale swing makes the q31 filter wrap
		cfg_write(REG_DC_ENABLE, 1'b1);
		settings_used++;
		send_sample(32'h0);
		send_sample(32'h0);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0);
		send_sample(32'h0);
		send_sample(32'h8000_0000);
		stop_sending();
		settle();

		// stereo with dc blocking: two dropped frames, one kept frame with
		// opposite extremes per channel, then a left sample to sit mid-frame
		cfg_write(REG_STEREO_MODE, 1'b1);
		settings_used++;
		repeat (4) send_sample($urandom);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample($urandom);
		stop_sending();
		settle();

		// mode flipped with no samples in between: stereo resumes on the right
		cfg_write(REG_STEREO_MODE, 1'b0);
		cfg_write(REG_STEREO_MODE, 1'b1);
		settings_used += 2;
		send_sample($urandom);
		send_sample($urandom);
		stop_sending();
		settle();

		// mono ignores the pending right channel and ends the frame anyway
		cfg_write(REG_STEREO_MODE, 1'b0);
		settings_used++;
		send_sample($urandom);
		send_sample(32'hFFFF_0000);
		stop_sending();
		settle();

		// random phases: first four walk every mode pair, the rest are random;
		// odd sample counts leave switches landing mid-frame
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 4) begin
				st = p[0];
				dc = p[1];
			end else begin
				st = 1'($urandom_range(0, 1));
				dc = 1'($urandom_range(0, 1));
			end
			cfg_write(REG_STEREO_MODE, st);
			cfg_write(REG_DC_ENABLE, dc);
			settings_used++;
			case (p % 3)
				0: stall_pct <= 0;
				1: stall_pct <= 25;
				default: stall_pct <= 65;
			endcase
			steady_sender = (p % 4 == 1);
			pressure_on <= (p == 2 || p == 6);
			dc_level = $urandom;
			n = $urandom_range(170, 230);
			for (int i = 0; i < n; i++)
				send_sample(pick_sample(dc_level));
			stop_sending();
			pressure_on <= 1'b0;
			settle();
		end

		settle();
		$display("covered %0d sample requests and %0d decimated results over %0d settings",
			requests_taken, results_checked, settings_used);
		$display("mono and stereo, dc blocking on and off, mid-frame switches, long output holds");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### files.f
design/dcdec_pkg.sv
design/dcdec_framer.sv
design/dcdec_filter.sv
design/decimate_and_dc_block_top.sv
design/dcdec_checker.sv
sim/dcdec_check.sv
sim/tb_decimate_and_dc_block_top.sv
